// ===== rtl/ufr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types, codes and CRC-8 helper for the register datagram framer.
// ----------------------------------------------------------------------------
`default_nettype none

package ufr_pkg;

    localparam int WINDOW_BYTES_DEF = 12;
    localparam int FRAME_BYTES      = 8;

    localparam logic [7:0] SYNC_BYTE   = 8'h05;
    localparam logic [7:0] WRITE_FLAG  = 8'h80;
    localparam logic [7:0] MASTER_ADDR = 8'hFF;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    localparam logic [3:0] REQ_WRITE_BYTES = 4'd8;
    localparam logic [3:0] REQ_READ_BYTES  = 4'd4;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RX      = 2'd2,
        CMD_TIMEOUT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_OK      = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_NO_RESP = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_HUNT  = 4'b0010,
        PH_SYNC  = 4'b0100,
        PH_FRAME = 4'b1000
    } phase_t;

    // One input request as held in the input register
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  node_address;
        logic [6:0]  register_index;
        logic [31:0] write_value;
        logic [7:0]  rx_byte;
    } ufr_item_t;

    // Result batch for one request: count results, bytes[0] goes out first
    typedef struct packed {
        logic [3:0]      count;
        kind_t           kind;
        logic [7:0][7:0] bytes;
        logic [31:0]     value;
    } ufr_res_t;

    // Feed one byte into the CRC, LSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        logic       mix;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[7] ^ data[i];
            c   = {c[6:0], 1'b0};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    localparam logic [7:0] CRC_SYNC_MASTER =
        crc8_feed(crc8_feed(8'h00, SYNC_BYTE), MASTER_ADDR);

endpackage

`default_nettype wire

// ===== rtl/ufr_in_reg.sv =====
// ----------------------------------------------------------------------------
// ufr_in_reg
// Input register: holds one request until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_in_reg
    import ufr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [55:0] s_tdata,
    input  wire logic [1:0] s_tuser,
    input  wire logic       take,
    output logic            item_valid,
    output ufr_item_t       item
);

    logic      valid_reg;
    ufr_item_t item_reg;

    // Free when empty or when the held request leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.cmd            <= cmd_t'(s_tuser);
            item_reg.node_address   <= s_tdata[7:0];
            item_reg.register_index <= s_tdata[14:8];
            item_reg.write_value    <= s_tdata[46:15];
            item_reg.rx_byte        <= s_tdata[54:47];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ufr_core.sv =====
// ----------------------------------------------------------------------------
// ufr_core
// Datagram builder and receive-window hunter; one request per cycle while take is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_core
    import ufr_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic take,
    input  ufr_item_t item,
    output ufr_res_t  res
);

    localparam logic [4:0] WIN5 = 5'(WINDOW_BYTES);
    localparam logic [3:0] WIN4 = 4'(WINDOW_BYTES);

    phase_t      phase_reg,  phase_next;
    logic [3:0]  wcount_reg, wcount_next;
    logic [2:0]  fidx_reg,   fidx_next;
    logic [7:0]  crc_reg,    crc_next;
    logic [31:0] value_reg,  value_next;
    logic        done_reg,   done_next;

    logic [7:0] reg_byte;
    logic [7:0] wcrc0, wcrc1, wcrc2, wcrc3, wcrc4, wcrc5, wcrc6;
    logic [7:0] rcrc2;
    logic       room;
    logic       is_sync;
    logic       frame_end;
    logic [3:0] wcount_inc;

    assign reg_byte = {1'b0, item.register_index};

    // Header CRC, shared by both request kinds up to the register byte
    assign wcrc0 = crc8_feed(8'h00, SYNC_BYTE);
    assign wcrc1 = crc8_feed(wcrc0, item.node_address);
    assign wcrc2 = crc8_feed(wcrc1, reg_byte | WRITE_FLAG);
    assign rcrc2 = crc8_feed(wcrc1, reg_byte);
    assign wcrc3 = crc8_feed(wcrc2, item.write_value[31:24]);
    assign wcrc4 = crc8_feed(wcrc3, item.write_value[23:16]);
    assign wcrc5 = crc8_feed(wcrc4, item.write_value[15:8]);
    assign wcrc6 = crc8_feed(wcrc5, item.write_value[7:0]);

    assign room       = ({1'b0, wcount_reg} + 5'(FRAME_BYTES)) <= WIN5;
    assign is_sync    = item.rx_byte == SYNC_BYTE;
    assign wcount_inc = wcount_reg + 4'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        wcount_next = wcount_reg;
        fidx_next   = fidx_reg;
        crc_next    = crc_reg;
        value_next  = value_reg;
        done_next   = done_reg;
        frame_end   = 1'b0;
        res         = '0;
        res.kind    = KIND_TX;

        case (item.cmd)
            CMD_WRITE:
            begin
                phase_next   = PH_IDLE;
                wcount_next  = '0;
                fidx_next    = '0;
                crc_next     = '0;
                value_next   = '0;
                done_next    = 1'b1;
                res.count    = REQ_WRITE_BYTES;
                res.bytes[0] = SYNC_BYTE;
                res.bytes[1] = item.node_address;
                res.bytes[2] = reg_byte | WRITE_FLAG;
                res.bytes[3] = item.write_value[31:24];
                res.bytes[4] = item.write_value[23:16];
                res.bytes[5] = item.write_value[15:8];
                res.bytes[6] = item.write_value[7:0];
                res.bytes[7] = wcrc6;
            end
            CMD_READ:
            begin
                phase_next   = PH_HUNT;
                wcount_next  = '0;
                fidx_next    = '0;
                crc_next     = '0;
                value_next   = '0;
                done_next    = 1'b0;
                res.count    = REQ_READ_BYTES;
                res.bytes[0] = SYNC_BYTE;
                res.bytes[1] = item.node_address;
                res.bytes[2] = reg_byte;
                res.bytes[3] = rcrc2;
            end
            CMD_TIMEOUT:
            begin
                if (!done_reg)
                begin
                    phase_next  = PH_IDLE;
                    wcount_next = '0;
                    fidx_next   = '0;
                    crc_next    = '0;
                    value_next  = '0;
                    done_next   = 1'b1;
                    res.count   = 4'd1;
                    res.kind    = KIND_NO_RESP;
                end
            end
            CMD_RX:
            begin
                if (!done_reg && phase_reg != PH_IDLE)
                begin
                    wcount_next = wcount_inc;
                    case (phase_reg)
                        PH_HUNT:
                        begin
                            if (is_sync && room)
                            begin
                                phase_next = PH_SYNC;
                            end
                        end
                        PH_SYNC:
                        begin
                            if (item.rx_byte == MASTER_ADDR)
                            begin
                                phase_next = PH_FRAME;
                                crc_next   = CRC_SYNC_MASTER;
                                fidx_next  = 3'd2;
                                value_next = '0;
                            end
                            else if (!(is_sync && room))
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_FRAME:
                        begin
                            if (fidx_reg == 3'd7)
                            begin
                                // CRC byte: report and close
                                frame_end = 1'b1;
                                res.count = 4'd1;
                                if (crc_reg == item.rx_byte)
                                begin
                                    res.kind  = KIND_OK;
                                    res.value = value_reg;
                                end
                                else
                                begin
                                    res.kind = KIND_CRC_ERR;
                                end
                            end
                            else
                            begin
                                crc_next  = crc8_feed(crc_reg, item.rx_byte);
                                fidx_next = fidx_reg + 3'd1;
                                if (fidx_reg >= 3'd3)
                                begin
                                    value_next = {value_reg[23:0], item.rx_byte};
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase

                    if (!frame_end && wcount_inc >= WIN4)
                    begin
                        res.count = 4'd1;
                        res.kind  = KIND_NO_RESP;
                    end
                    if (frame_end || wcount_inc >= WIN4)
                    begin
                        phase_next  = PH_IDLE;
                        wcount_next = '0;
                        fidx_next   = '0;
                        crc_next    = '0;
                        value_next  = '0;
                        done_next   = 1'b1;
                    end
                end
            end
            default:
            begin
                res.count = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            wcount_reg <= '0;
            fidx_reg   <= '0;
            crc_reg    <= '0;
            value_reg  <= '0;
            done_reg   <= 1'b1;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            wcount_reg <= wcount_next;
            fidx_reg   <= fidx_next;
            crc_reg    <= crc_next;
            value_reg  <= value_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ufr_emit.sv =====
// ----------------------------------------------------------------------------
// ufr_emit
// Result buffer: holds one request's results and drains them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_emit
    import ufr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  ufr_res_t    res,
    output logic        load_ready,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output logic [7:0]  tx_byte,
    output logic [31:0] read_value,
    output kind_t       kind,
    output logic        last
);

    logic [3:0]      count_reg;
    logic [2:0]      idx_reg;
    logic [7:0][7:0] bytes_reg;
    kind_t           kind_reg;
    logic [31:0]     value_reg;
    logic            beat;

    assign m_tvalid   = count_reg != 4'd0;
    assign beat       = m_tvalid && m_tready;
    assign last       = count_reg == 4'd1;
    // Refill as the last result leaves
    assign load_ready = !m_tvalid || (last && m_tready);

    assign tx_byte    = bytes_reg[idx_reg];
    assign read_value = value_reg;
    assign kind       = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            count_reg <= res.count;
            idx_reg   <= '0;
        end
        else if (beat)
        begin
            count_reg <= count_reg - 4'd1;
            idx_reg   <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= res.bytes;
            kind_reg  <= res.kind;
            value_reg <= res.value;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uart_register_datagram_framer.sv =====
// ----------------------------------------------------------------------------
// uart_register_datagram_framer
// Host-side framer for a CRC-8 protected single-wire register protocol.
// ----------------------------------------------------------------------------
// Use:
//   The slave stream carries requests: tuser selects write request, read
//   request, received line byte or receive timeout; tdata carries the node,
//   register, write value and received byte. The master stream returns
//   results: tuser gives the kind (transmit byte, read value, CRC error,
//   no response), tdata the byte to send and the read value, tlast marks
//   the final result of each request.
//   A write request yields 8 transmit bytes, a read request 4 bytes and
//   opens a receive window; received bytes and timeouts give at most one
//   result, many give none.
// Timing:
//   A request passes from the input register via the combinational core to
//   the result buffer. Requests with zero or one result flow at one per
//   cycle while m_tready is high; a datagram holds the buffer until its 4
//   or 8 bytes leave its single-byte port, one byte per cycle with m_tready.
// Reset:
//   Both stages empty, no receive window open.
// Stall:
//   When the master side stalls, the result holds; the input register still
//   takes one more request and then drops s_tready until the buffer frees.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_datagram_framer
    import ufr_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // node_address[7:0], register_index[14:8], write_value[46:15],
    // rx_byte[54:47], zero pad[55]
    input  wire logic [55:0] s_tdata,
    // command[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tx_byte[7:0], read_value[39:8]
    output logic [39:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    ufr_item_t   item;
    ufr_res_t    res;
    logic        item_valid;
    logic        load_ready;
    logic        take;
    logic [7:0]  tx_byte;
    logic [31:0] read_value;
    kind_t       kind;

    // Advance a request into the result buffer when it has room
    assign take = item_valid && load_ready;

    ufr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ufr_core #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .res   (res)
    );

    ufr_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .res        (res),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .tx_byte    (tx_byte),
        .read_value (read_value),
        .kind       (kind),
        .last       (m_tlast)
    );

    assign m_tdata = {read_value, tx_byte};
    assign m_tuser = kind;

endmodule

`default_nettype wire

// ===== rtl/ufr_checker.sv =====
// ----------------------------------------------------------------------------
// ufr_checker
// Port-level checks on the framer's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_checker
    import ufr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped or changed while stalled");

    // Status results stand alone
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_TX |-> m_tlast)
        else $error("status result not marked last");

    // Status results carry no transmit byte
    a_status_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_TX |-> m_tdata[7:0] == 8'h00)
        else $error("status result with transmit byte");

    // Read value only on a good response
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_OK |-> m_tdata[39:8] == 32'h0)
        else $error("read value outside a good response");

    // A datagram continues with its next byte
    a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == KIND_TX)
        else $error("datagram broken off");

endmodule

bind uart_register_datagram_framer ufr_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/uart_register_datagram_framer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_register_datagram_framer_tb
// Self-checking bench for the register datagram framer. A driver feeds
// requests from a queue with random gaps, a model of the host-side
// protocol predicts every result, and a monitor with random back-pressure
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module uart_register_datagram_framer_tb;
    import ufr_pkg::*;

    localparam int RX_WINDOW    = WINDOW_BYTES_DEF;
    localparam int RANDOM_ITEMS = 430;
    localparam int TAIL_CYCLES  = 16;
    localparam int MAX_REPORTS  = 40;

    // One request as it travels on the slave stream
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  node_address;
        logic [6:0]  register_index;
        logic [31:0] write_value;
        logic [7:0]  rx_byte;
    } framer_req_t;

    // One result as it should appear on the master stream
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] read_value;
    } framer_res_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // node_address[7:0], register_index[14:8], write_value[46:15],
    // rx_byte[54:47], zero pad[55]
    logic [55:0] s_tdata  = '0;
    // command[1:0]
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tx_byte[7:0], read_value[39:8]
    logic [39:0] m_tdata;
    // kind[1:0]
    logic [1:0]  m_tuser;
    logic        m_tlast;

    uart_register_datagram_framer #(
        .WINDOW_BYTES (RX_WINDOW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Receive-window state of the protocol model, at reset values
    phase_t      rx_phase      = PH_IDLE;
    logic [3:0]  rx_count      = '0;
    logic [2:0]  frame_pos     = '0;
    logic [7:0]  frame_crc     = '0;
    logic [31:0] frame_value   = '0;
    logic        window_closed = 1'b1;

    framer_req_t host_requests[$];
    framer_res_t host_results[$];
    int          error_count = 0;
    int          stim_count  = 0;

    // CRC-8, polynomial 0x07, data bits taken LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
        for (int i = 0; i < 8; i++)
        begin
            if (acc[7] ^ data[i])
            begin
                acc = {acc[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                acc = {acc[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

    // Idle length: mostly none or short, a few long, and now and then a
    // calm stretch with no idling at all
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Response datagram from the device, byte 0 in the low bits
    function automatic logic [63:0] response_frame(input logic [7:0] reg_byte,
                                                   input logic [31:0] value);
        logic [63:0] f;
        logic [7:0]  crc;
        f   = {8'h00, value[7:0], value[15:8], value[23:16], value[31:24],
               reg_byte, MASTER_ADDR, SYNC_BYTE};
        crc = 8'h00;
        for (int k = 0; k < 7; k++)
        begin
            crc = crc8_byte(crc, f[8*k +: 8]);
        end
        f[63:56] = crc;
        return f;
    endfunction

    task automatic close_window();
        rx_phase      = PH_IDLE;
        rx_count      = '0;
        frame_pos     = '0;
        frame_crc     = '0;
        frame_value   = '0;
        window_closed = 1'b1;
    endtask

    task automatic push_result(input kind_t kind, input logic [7:0] tx, input logic last,
                               input logic [31:0] value);
        framer_res_t res;
        res.kind       = kind;
        res.tx_byte    = tx;
        res.last       = last;
        res.read_value = value;
        host_results.push_back(res);
    endtask

    // Advance the protocol model by one accepted request and queue its results
    task automatic advance_framer(input framer_req_t r);
        logic [7:0]  dg [8];
        logic [7:0]  crc;
        int          n;
        logic        room;
        logic        ok;
        logic [31:0] v;
        crc = 8'h00;
        n   = 0;
        case (r.cmd)
            CMD_WRITE, CMD_READ:
            begin
                // a write or read request drops an open window silently
                close_window();
                dg[0] = SYNC_BYTE;
                dg[1] = r.node_address;
                if (r.cmd == CMD_WRITE)
                begin
                    dg[2] = {1'b0, r.register_index} | WRITE_FLAG;
                    dg[3] = r.write_value[31:24];
                    dg[4] = r.write_value[23:16];
                    dg[5] = r.write_value[15:8];
                    dg[6] = r.write_value[7:0];
                    n     = 8;
                end
                else
                begin
                    dg[2]         = {1'b0, r.register_index};
                    n             = 4;
                    rx_phase      = PH_HUNT;
                    window_closed = 1'b0;
                end
                for (int k = 0; k < n - 1; k++)
                begin
                    crc = crc8_byte(crc, dg[k]);
                end
                dg[n-1] = crc;
                for (int k = 0; k < n; k++)
                begin
                    push_result(KIND_TX, dg[k], k == n - 1, 32'h0);
                end
            end
            CMD_TIMEOUT:
            begin
                if (!window_closed)
                begin
                    close_window();
                    push_result(KIND_NO_RESP, 8'h00, 1'b1, 32'h0);
                end
            end
            CMD_RX:
            begin
                if (!window_closed && rx_phase != PH_IDLE)
                begin
                    // a sync only counts if a whole frame still fits
                    room     = (int'(rx_count) + FRAME_BYTES) <= RX_WINDOW;
                    rx_count = rx_count + 4'd1;
                    case (rx_phase)
                        PH_HUNT:
                        begin
                            if (r.rx_byte == SYNC_BYTE && room)
                                rx_phase = PH_SYNC;
                        end
                        PH_SYNC:
                        begin
                            if (r.rx_byte == MASTER_ADDR)
                            begin
                                rx_phase    = PH_FRAME;
                                frame_crc   = crc8_byte(crc8_byte(8'h00, SYNC_BYTE),
                                                        MASTER_ADDR);
                                frame_pos   = 3'd2;
                                frame_value = '0;
                            end
                            else if (!(r.rx_byte == SYNC_BYTE && room))
                            begin
                                rx_phase = PH_HUNT;
                            end
                        end
                        default:
                        begin
                            if (frame_pos >= 3'd7)
                            begin
                                ok = (frame_crc == r.rx_byte);
                                v  = frame_value;
                                close_window();
                                push_result(ok ? KIND_OK : KIND_CRC_ERR, 8'h00, 1'b1,
                                            ok ? v : 32'h0);
                            end
                            else
                            begin
                                // register byte feeds the CRC only
                                frame_crc = crc8_byte(frame_crc, r.rx_byte);
                                if (frame_pos >= 3'd3)
                                    frame_value = {frame_value[23:0], r.rx_byte};
                                frame_pos = frame_pos + 3'd1;
                            end
                        end
                    endcase
                    // window full without a finished frame
                    if (rx_count >= RX_WINDOW)
                    begin
                        close_window();
                        push_result(KIND_NO_RESP, 8'h00, 1'b1, 32'h0);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_request(input cmd_t cmd, input logic [7:0] node,
                                 input logic [6:0] reg_index, input logic [31:0] value,
                                 input logic [7:0] rx, input bit counted);
        framer_req_t r;
        r.cmd            = cmd;
        r.node_address   = node;
        r.register_index = reg_index;
        r.write_value    = value;
        r.rx_byte        = rx;
        host_requests.push_back(r);
        if (counted)
            stim_count++;
    endtask

    // Line byte with random contents in the unused fields
    task automatic queue_rx(input logic [7:0] b, input bit counted);
        queue_request(CMD_RX, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                      $urandom, b, counted);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: hold each request until accepted, then idle for a random gap
    // ------------------------------------------------------------------
    framer_req_t drive_req;
    bit          in_holding = 1'b0;
    int          in_gap     = 0;
    int          in_calm    = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            in_holding = 1'b0;
        end
        else
        begin
            // request taken at this edge: run it through the model
            if (s_tvalid && s_tready)
            begin
                advance_framer(drive_req);
                in_holding = 1'b0;
            end
            if (!in_holding)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (host_requests.size() > 0)
                begin
                    drive_req  = host_requests.pop_front();
                    s_tdata    <= {1'b0, drive_req.rx_byte, drive_req.write_value,
                                   drive_req.register_index, drive_req.node_address};
                    s_tuser    <= drive_req.cmd;
                    s_tvalid   <= 1'b1;
                    in_holding = 1'b1;
                    in_gap     = idle_len(in_calm);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result, stall the master side at random
    // ------------------------------------------------------------------
    int out_stall = 0;
    int out_calm  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin : check_result
                framer_res_t want;
                if (host_results.size() == 0)
                begin
                    report_mismatch("result with nothing pending", {30'h0, m_tuser}, 32'h0);
                end
                else
                begin
                    want = host_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch("kind", {30'h0, m_tuser}, {30'h0, want.kind});
                    if (m_tdata[7:0] !== want.tx_byte)
                        report_mismatch("tx_byte", {24'h0, m_tdata[7:0]},
                                        {24'h0, want.tx_byte});
                    if (m_tlast !== want.last)
                        report_mismatch("last", {31'h0, m_tlast}, {31'h0, want.last});
                    if (m_tdata[39:8] !== want.read_value)
                        report_mismatch("read_value", m_tdata[39:8], want.read_value);
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_stall = idle_len(out_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed cases, then random protocol traffic, then drain
    // ------------------------------------------------------------------
    initial
    begin
        int          sel;
        int          lead;
        int          cut;
        int          n;
        logic [63:0] frame;
        logic [7:0]  b;
        logic [31:0] val;

        // write datagrams at both field extremes
        queue_request(CMD_WRITE, 8'h00, 7'h00, 32'h0000_0000, 8'h00, 1'b1);
        queue_request(CMD_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        // line byte with no window open: dropped
        queue_rx(SYNC_BYTE, 1'b1);
        // read, then a write while the window is still open
        queue_request(CMD_READ, 8'h3C, 7'h01, $urandom, 8'($urandom_range(0, 255)), 1'b1);
        queue_request(CMD_WRITE, 8'hA5, 7'h42, 32'h1234_5678, 8'h00, 1'b1);
        // timeout with no window open: dropped
        queue_request(CMD_TIMEOUT, 8'h00, 7'h00, 32'h0, 8'h00, 1'b1);
        // read answered by a clean frame
        queue_request(CMD_READ, 8'h5A, 7'h11, 32'h0, 8'h00, 1'b1);
        frame = response_frame(8'h11, 32'hDEAD_BEEF);
        for (int k = 0; k < 8; k++)
            queue_rx(frame[8*k +: 8], 1'b1);
        // read whose window fills up; the syncs arrive too late to frame
        queue_request(CMD_READ, 8'h01, 7'h20, 32'h0, 8'h00, 1'b1);
        queue_rx(8'h00, 1'b1);
        queue_rx(8'h11, 1'b1);
        queue_rx(8'h22, 1'b1);
        queue_rx(8'h33, 1'b1);
        queue_rx(8'h44, 1'b1);
        queue_rx(SYNC_BYTE, 1'b1);
        queue_rx(MASTER_ADDR, 1'b1);
        queue_rx(SYNC_BYTE, 1'b1);
        queue_rx(MASTER_ADDR, 1'b1);
        queue_rx(8'h00, 1'b1);
        queue_rx(8'hFF, 1'b1);
        queue_rx(SYNC_BYTE, 1'b1);
        // read closed by a timeout
        queue_request(CMD_READ, 8'h80, 7'h40, 32'h0, 8'h00, 1'b1);
        queue_request(CMD_TIMEOUT, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF, 1'b1);

        stim_count = 0;
        while (stim_count < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       val = 32'h0000_0000;
                1:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            if (sel < 15)
            begin
                queue_request(CMD_WRITE, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), val,
                              8'($urandom_range(0, 255)), 1'b1);
            end
            else if (sel < 70)
            begin
                // read with a response: some leading noise, then a frame that
                // may carry a bad CRC or be cut short
                queue_request(CMD_READ, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), $urandom,
                              8'($urandom_range(0, 255)), 1'b1);
                lead = $urandom_range(0, RX_WINDOW - FRAME_BYTES);
                for (int k = 0; k < lead; k++)
                begin
                    b = ($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255));
                    queue_rx(b, 1'b1);
                end
                frame = response_frame(8'($urandom_range(0, 255)), val);
                if ($urandom_range(0, 3) == 0)
                    frame[63:56] = frame[63:56] ^ 8'($urandom_range(1, 255));
                cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 7) : 8;
                for (int k = 0; k < cut; k++)
                    queue_rx(frame[8*k +: 8], 1'b1);
                if (cut < 8 && $urandom_range(0, 1) == 1)
                begin
                    queue_request(CMD_TIMEOUT, 8'($urandom_range(0, 255)),
                                  7'($urandom_range(0, 127)), $urandom,
                                  8'($urandom_range(0, 255)), 1'b1);
                end
                // stray bytes after the frame fall on a closed window
                if (cut == 8 && $urandom_range(0, 4) == 0)
                begin
                    n = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++)
                        queue_rx(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            else if (sel < 82)
            begin
                // read followed by line noise rich in sync and address bytes
                queue_request(CMD_READ, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), $urandom,
                              8'($urandom_range(0, 255)), 1'b1);
                n = $urandom_range(0, RX_WINDOW + 2);
                for (int k = 0; k < n; k++)
                begin
                    case ($urandom_range(0, 6))
                        0, 1:    b = SYNC_BYTE;
                        2:       b = MASTER_ADDR;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    queue_rx(b, 1'b1);
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    queue_request(CMD_TIMEOUT, 8'($urandom_range(0, 255)),
                                  7'($urandom_range(0, 127)), $urandom,
                                  8'($urandom_range(0, 255)), 1'b1);
                end
            end
            else if (sel < 92)
            begin
                // fully random request of any command
                queue_request(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), val,
                              8'($urandom_range(0, 255)), 1'b1);
            end
            else
            begin
                queue_request(CMD_READ, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), $urandom,
                              8'($urandom_range(0, 255)), 1'b1);
                queue_request(CMD_TIMEOUT, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), $urandom,
                              8'($urandom_range(0, 255)), 1'b1);
            end
        end

        // drain: every request taken and every predicted result seen
        while (host_requests.size() > 0 || in_holding || host_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog for a hung handshake
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ufr_pkg.sv
rtl/ufr_in_reg.sv
rtl/ufr_core.sv
rtl/ufr_emit.sv
rtl/uart_register_datagram_framer.sv
rtl/ufr_checker.sv
tb/uart_register_datagram_framer_tb.sv
